@@ rtl/core/sfmd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfmd_pkg: shared types and constants of the sync-framed message deframer
// Holds register defaults, the payload length lookup and the interface
// structs between the header parser and the payload buffer.
// ----------------------------------------------------------------------------
package sfmd_pkg;

   // deepest payload buffer the byte index can address
   localparam int STORE_DEPTH         = 16;
   localparam int DEFAULT_MAX_PAYLOAD = 16;
   localparam int IDX_W               = 4;
   localparam int LEN_W               = 5;

   // preamble bytes that must match before the unchecked fourth byte
   localparam logic [1:0] SYNC_NEEDED = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_SYNC_CODE       = 3'd0;
   localparam logic [2:0] CSR_VT_FLOOR        = 3'd1;
   localparam logic [2:0] CSR_VT_CEILING      = 3'd2;
   localparam logic [2:0] CSR_MT_FLOOR        = 3'd3;
   localparam logic [2:0] CSR_MT_CEILING      = 3'd4;

   // configuration register reset values
   localparam logic [7:0] RST_SYNC_CODE       = 8'd255;
   localparam logic [7:0] RST_VT_FLOOR        = 8'd0;
   localparam logic [7:0] RST_VT_CEILING      = 8'd9;
   localparam logic [7:0] RST_MT_FLOOR        = 8'd0;
   localparam logic [7:0] RST_MT_CEILING      = 8'd4;

   // payload buffer write port
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } buf_wr_type;

   // request to play back a completed message
   typedef struct packed {
      logic             start;
      logic [IDX_W-1:0] last_idx;
      logic [7:0]       value_type;
      logic [7:0]       message_type;
   } emit_cmd_type;

   // payload length by value type; zero and unknown lengths count as one byte
   function automatic logic [LEN_W-1:0] len_lookup(input logic [7:0] vt);
      logic [LEN_W-1:0] len;
      case (vt)
         8'd1:    len = 5'd16;
         8'd2:    len = 5'd1;
         8'd3:    len = 5'd1;
         8'd4:    len = 5'd1;
         8'd5:    len = 5'd1;
         8'd6:    len = 5'd1;
         8'd7:    len = 5'd3;
         8'd8:    len = 5'd5;
         default: len = 5'd1;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/core/sfmd_payload_buf.sv @@
// ----------------------------------------------------------------------------
// sfmd_payload_buf: payload memory and message playback
// Stores payload bytes as they arrive and, on command, reads the message
// back one entry per cycle, unless stalled, into a stall-safe output register.
// ----------------------------------------------------------------------------
module sfmd_payload_buf
   import sfmd_pkg::*;
#(
   parameter int DEPTH = STORE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  buf_wr_type       wr,
   input  emit_cmd_type     cmd,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_value_type,
   output logic [7:0]       rsp_message_type,
   output logic [7:0]       rsp_payload_byte,
   output logic [3:0]       rsp_byte_index,
   output logic             rsp_last_byte
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] mem [DEPTH];

   logic          active_ff, active_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] last_ff, last_in;
   logic [7:0]    vt_ff, vt_in;
   logic [7:0]    mt_ff, mt_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic          pend_last_ff, pend_last_in;
   logic [7:0]    pend_vt_ff, pend_vt_in;
   logic [7:0]    pend_mt_ff, pend_mt_in;
   logic [7:0]    rd_data_ff;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_vt_ff, out_mt_ff, out_byte_ff;
   logic [IW-1:0] out_idx_ff;
   logic          out_last_ff;

   logic load;
   logic rd_en;

   // move read data into the output register when it is free or being taken
   assign load  = pend_ff && (!out_valid_ff || !rsp_stall);
   // issue a read only when its data has somewhere to go
   assign rd_en = active_ff && (!pend_ff || load);

   always_comb begin
      active_in    = active_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      vt_in        = vt_ff;
      mt_in        = mt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      pend_vt_in   = pend_vt_ff;
      pend_mt_in   = pend_mt_ff;
      out_valid_in = out_valid_ff;

      if (rd_en) begin
         pend_in      = 1'b1;
         pend_idx_in  = k_ff;
         pend_last_in = (k_ff == last_ff);
         // carry the message types with the read so a new message can start
         pend_vt_in   = vt_ff;
         pend_mt_in   = mt_ff;
         if (k_ff == last_ff) begin
            active_in = 1'b0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end else if (load) begin
         pend_in = 1'b0;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (cmd.start) begin
         active_in = 1'b1;
         k_in      = '0;
         last_in   = cmd.last_idx[IW-1:0];
         vt_in     = cmd.value_type;
         mt_in     = cmd.message_type;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff         <= k_in;
      last_ff      <= last_in;
      vt_ff        <= vt_in;
      mt_ff        <= mt_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      pend_vt_ff   <= pend_vt_in;
      pend_mt_ff   <= pend_mt_in;
      if (load) begin
         out_vt_ff   <= pend_vt_ff;
         out_mt_ff   <= pend_mt_ff;
         out_byte_ff <= rd_data_ff;
         out_idx_ff  <= pend_idx_ff;
         out_last_ff <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr[IW-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[k_ff];
      end
   end

   assign busy             = active_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_value_type   = out_vt_ff;
   assign rsp_message_type = out_mt_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_byte_index   = 4'(out_idx_ff);
   assign rsp_last_byte    = out_last_ff;

endmodule

@@ rtl/core/sync_framed_message_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_framed_message_deframer: byte-stream deframer for sync-framed messages
// Hunts for a four-byte sync preamble (fourth byte unchecked), validates
// the value and message type bytes, buffers the payload, then plays it back.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one received byte per transfer. Header bytes are consumed
//          silently; a failed sync or range check drops back to sync search.
//   rsp_*  carries the completed message, one transfer per payload byte,
//          with rsp_last_byte marking the final one. Every result carries the
//          validated value type and message type.
//   csr_*  writes the sync code and the type bounds; write only when idle.
// Timing:
//   Outside playback a byte is taken every cycle. The final payload byte of
//   an N-byte message (N up to 16) starts playback from the payload memory:
//   the playback command is registered, then the memory read, then the
//   output register, after which one result follows per cycle while rsp
//   is not stalled. req_stall is high while the memory read port walks the
//   message, so no new byte is taken until the walk has finished.
// Reset clears the parser to sync search and restores register defaults;
// the payload memory is not cleared. A stall on rsp holds the output
// register, and playback pauses with it.
// ----------------------------------------------------------------------------
module sync_framed_message_deframer
   import sfmd_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_value_type,
   output logic [7:0] rsp_message_type,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_byte_index,
   output logic       rsp_last_byte,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // buffer depth: payload cap, limited by what the byte index can address
   localparam int DEPTH = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // parser phases
   localparam logic [2:0] PH_FIND    = 3'd0;
   localparam logic [2:0] PH_SYNC    = 3'd1;
   localparam logic [2:0] PH_VALTYPE = 3'd2;
   localparam logic [2:0] PH_MSGTYPE = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [7:0] sync_code_ff;
   logic [7:0] vt_floor_ff, vt_ceiling_ff;
   logic [7:0] mt_floor_ff, mt_ceiling_ff;

   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    sync_cnt_ff, sync_cnt_in;
   logic [7:0]    held_vt_ff, held_vt_in;
   logic [7:0]    held_mt_ff, held_mt_in;
   logic [IW-1:0] pcount_ff, pcount_in;

   logic             accept;
   logic             busy;
   logic [LEN_W-1:0] table_len;
   logic [LEN_W-1:0] len_m1;
   logic             last_payload;
   buf_wr_type       wr;
   emit_cmd_type     cmd;

   // hold input while the buffer plays back a message
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_code_ff  <= RST_SYNC_CODE;
         vt_floor_ff   <= RST_VT_FLOOR;
         vt_ceiling_ff <= RST_VT_CEILING;
         mt_floor_ff   <= RST_MT_FLOOR;
         mt_ceiling_ff <= RST_MT_CEILING;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_CODE:  sync_code_ff  <= csr_wdata;
            CSR_VT_FLOOR:   vt_floor_ff   <= csr_wdata;
            CSR_VT_CEILING: vt_ceiling_ff <= csr_wdata;
            CSR_MT_FLOOR:   mt_floor_ff   <= csr_wdata;
            CSR_MT_CEILING: mt_ceiling_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // message length minus one, capped at the buffer depth
   assign table_len    = len_lookup(held_vt_ff);
   assign len_m1       = ((table_len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : table_len) - 1'b1;
   assign last_payload = (LEN_W'(pcount_ff) == len_m1);

   always_comb begin
      phase_in    = phase_ff;
      sync_cnt_in = sync_cnt_ff;
      held_vt_in  = held_vt_ff;
      held_mt_in  = held_mt_ff;
      pcount_in   = pcount_ff;

      wr.we   = 1'b0;
      wr.addr = 4'(pcount_ff);
      wr.data = req_rx_byte;

      cmd.start        = 1'b0;
      cmd.last_idx     = 4'(pcount_ff);
      cmd.value_type   = held_vt_ff;
      cmd.message_type = held_mt_ff;

      if (accept) begin
         case (phase_ff)
            PH_FIND: begin
               if (req_rx_byte == sync_code_ff) begin
                  phase_in    = PH_SYNC;
                  sync_cnt_in = 2'd1;
               end
            end
            PH_SYNC: begin
               if (sync_cnt_ff < SYNC_NEEDED) begin
                  if (req_rx_byte == sync_code_ff) begin
                     sync_cnt_in = sync_cnt_ff + 1'b1;
                  end else begin
                     phase_in    = PH_FIND;
                     sync_cnt_in = '0;
                     pcount_in   = '0;
                  end
               end else begin
                  // fourth header byte: consume unchecked
                  phase_in    = PH_VALTYPE;
                  sync_cnt_in = '0;
               end
            end
            PH_VALTYPE: begin
               if (req_rx_byte > vt_floor_ff && req_rx_byte < vt_ceiling_ff) begin
                  held_vt_in = req_rx_byte;
                  phase_in   = PH_MSGTYPE;
               end else begin
                  phase_in    = PH_FIND;
                  sync_cnt_in = '0;
                  pcount_in   = '0;
               end
            end
            PH_MSGTYPE: begin
               if (req_rx_byte > mt_floor_ff && req_rx_byte < mt_ceiling_ff) begin
                  held_mt_in = req_rx_byte;
                  phase_in   = PH_PAYLOAD;
                  pcount_in  = '0;
               end else begin
                  phase_in    = PH_FIND;
                  sync_cnt_in = '0;
                  pcount_in   = '0;
               end
            end
            PH_PAYLOAD: begin
               wr.we = 1'b1;
               if (last_payload) begin
                  // message complete: start playback, resume sync search
                  cmd.start   = 1'b1;
                  phase_in    = PH_FIND;
                  sync_cnt_in = '0;
                  pcount_in   = '0;
               end else begin
                  pcount_in = pcount_ff + 1'b1;
               end
            end
            default: begin
               phase_in    = PH_FIND;
               sync_cnt_in = '0;
               pcount_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIND;
         sync_cnt_ff <= '0;
         held_vt_ff  <= '0;
         held_mt_ff  <= '0;
         pcount_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         sync_cnt_ff <= sync_cnt_in;
         held_vt_ff  <= held_vt_in;
         held_mt_ff  <= held_mt_in;
         pcount_ff   <= pcount_in;
      end
   end

   sfmd_payload_buf #(
      .DEPTH (DEPTH)
   ) u_buf (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .cmd              (cmd),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value_type   (rsp_value_type),
      .rsp_message_type (rsp_message_type),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte)
   );

endmodule
